/* rtl/core/jhs_pkg.sv */
// ----------------------------------------------------------------------------
// jhs_pkg
// Shared constants, register map and helper types for the Jacobi stencil sweep.
// ----------------------------------------------------------------------------
package jhs_pkg;

    localparam int MAX_ROWS  = 1024;
    localparam int MAX_COLS  = 1024;
    localparam int MIN_SIZE  = 3;

    localparam int DATA_W    = 32;              // signed Q16.16 cell value
    localparam int SIZE_W    = 11;              // rows_used / cols_used
    localparam int IDX_W     = 10;              // row and column indices
    localparam int COL_AW    = $clog2(MAX_COLS);
    localparam int PADDR_W   = 5;
    localparam int APB_W     = 32;
    localparam int OUT_W     = 88;              // 84 payload bits padded to bytes

    // Register map, word index into the configuration space
    typedef enum logic [2:0] {
        REG_ROWS_USED  = 3'd0,
        REG_COLS_USED  = 3'd1,
        REG_HOT_ROW    = 3'd2,
        REG_HOT_COL    = 3'd3,
        REG_HOT_TEMP   = 3'd4,
        REG_HOT_ENABLE = 3'd5
    } t_reg_idx;

    localparam logic [SIZE_W-1:0] ROWS_RST     = SIZE_W'(1024);
    localparam logic [SIZE_W-1:0] COLS_RST     = SIZE_W'(1024);
    localparam logic [IDX_W-1:0]  HOT_ROW_RST  = IDX_W'(512);
    localparam logic [IDX_W-1:0]  HOT_COL_RST  = IDX_W'(512);
    localparam logic [DATA_W-1:0] HOT_TEMP_RST = DATA_W'(3276800);

    // Per-item control flags carried down the pipeline
    typedef struct packed {
        logic has_first;    // item emits the cell of the row above
        logic last_row;     // item emits its own cell as well
        logic row_inner;    // row above is an interior row
        logic col_inner;    // column is interior
        logic hot_first;    // cell above is the hot cell
        logic hot_last;     // this cell is the hot cell
        logic sweep_last;   // final cell of the sweep
        logic clr;          // first cell of the sweep
        logic b_zero;       // no right-hand neighbour in the line store
    } t_jhs_flags;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] res;
        if (v < SIZE_W'(MIN_SIZE)) begin
            res = SIZE_W'(MIN_SIZE);
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

/* rtl/core/jacobi_heat_stencil_sweep.sv */
// ----------------------------------------------------------------------------
// jacobi_heat_stencil_sweep
// One Jacobi five-point heat-diffusion sweep over a raster-ordered grid.
// ----------------------------------------------------------------------------
// The old grid streams in one signed Q16.16 cell per request in raster order,
// and the block takes one request per clock while the result side does not
// stall. The cell arriving at (r,c) puts the new value of (r-1,c) on the result
// port through the stage-1, stage-2, stage-3 and output registers; on the last
// row each request releases two results, so there the input is held back by
// the single output port. Two line stores, each a RAM of MAX_COLS words with a
// registered read, supply the rows above; the row above is read at two columns
// per request. The line stores are not cleared after reset and need no clearing
// pass. Configuration registers must only be written while the pipeline is
// empty.
module jacobi_heat_stencil_sweep (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [jhs_pkg::PADDR_W-1:0]       paddr,
    input  logic [jhs_pkg::APB_W-1:0]         pwdata,
    output logic [jhs_pkg::APB_W-1:0]         prdata,
    output logic                              pready,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [jhs_pkg::DATA_W-1:0]        s_axis_tdata,  // [31:0] old_value
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [31:0] new_value, [41:32] out_row, [51:42] out_col, [83:52] max_change
    output logic [jhs_pkg::OUT_W-1:0]         m_axis_tdata,
    output logic                              m_axis_tlast,  // run_last
    output logic                              m_axis_tuser   // sweep_last
);

    import jhs_pkg::*;

    // ---------------- configuration registers ----------------
    logic [SIZE_W-1:0] r_rows_used, r_cols_used;
    logic [IDX_W-1:0]  r_hot_row, r_hot_col;
    logic [DATA_W-1:0] r_hot_temp;
    logic              r_hot_enable;
    logic              cfg_wr;
    t_reg_idx          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_used  <= ROWS_RST;
            r_cols_used  <= COLS_RST;
            r_hot_row    <= HOT_ROW_RST;
            r_hot_col    <= HOT_COL_RST;
            r_hot_temp   <= HOT_TEMP_RST;
            r_hot_enable <= 1'b1;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ROWS_USED:  r_rows_used  <= pwdata[SIZE_W-1:0];
                REG_COLS_USED:  r_cols_used  <= pwdata[SIZE_W-1:0];
                REG_HOT_ROW:    r_hot_row    <= pwdata[IDX_W-1:0];
                REG_HOT_COL:    r_hot_col    <= pwdata[IDX_W-1:0];
                REG_HOT_TEMP:   r_hot_temp   <= pwdata[DATA_W-1:0];
                REG_HOT_ENABLE: r_hot_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_ROWS_USED:  prdata = APB_W'(r_rows_used);
            REG_COLS_USED:  prdata = APB_W'(r_cols_used);
            REG_HOT_ROW:    prdata = APB_W'(r_hot_row);
            REG_HOT_COL:    prdata = APB_W'(r_hot_col);
            REG_HOT_TEMP:   prdata = r_hot_temp;
            REG_HOT_ENABLE: prdata = APB_W'(r_hot_enable);
            default:        prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic r_v1, r_v2, r_v3, r_v4;
    logic [1:0] r_pend;     // [0] cell above still to send, [1] own cell
    logic free1, free2, free3, free4;
    logic adv1, adv2, adv3, acc, out_fire, s4_done, load4;
    logic [1:0] mask3;

    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign s4_done  = out_fire && (r_pend != 2'b11);
    assign free4    = !r_v4 || s4_done;
    assign adv3     = r_v3 && free4;
    assign free3    = !r_v3 || free4;
    assign adv2     = r_v2 && free3;
    assign free2    = !r_v2 || free3;
    assign adv1     = r_v1 && free2;
    assign free1    = !r_v1 || free2;
    assign s_axis_tready = free1;
    assign acc      = s_axis_tvalid && s_axis_tready;

    // ---------------- stage 0: position and flags ----------------
    logic [SIZE_W-1:0] rows, cols;
    logic [IDX_W-1:0]  r_row, r_col, n_row, n_col, r0, c0, tr0;
    logic [SIZE_W-1:0] c0_p1, r0_p1;
    logic              restart, col_wrap;
    t_jhs_flags        f0;

    always_comb begin
        rows    = clamp_size(r_rows_used, SIZE_W'(MAX_ROWS));
        cols    = clamp_size(r_cols_used, SIZE_W'(MAX_COLS));
        // A size change that leaves the counters off the grid restarts the sweep.
        restart = ({1'b0, r_row} >= rows) || ({1'b0, r_col} >= cols);
        r0      = restart ? '0 : r_row;
        c0      = restart ? '0 : r_col;
        tr0     = r0 - IDX_W'(1);
        c0_p1   = {1'b0, c0} + SIZE_W'(1);
        r0_p1   = {1'b0, r0} + SIZE_W'(1);
        col_wrap = c0_p1 >= cols;
        n_col   = col_wrap ? '0 : c0_p1[IDX_W-1:0];
        if (!col_wrap) begin
            n_row = r0;
        end else if (r0_p1 >= rows) begin
            n_row = '0;
        end else begin
            n_row = r0_p1[IDX_W-1:0];
        end

        f0.has_first  = r0 != '0;
        f0.last_row   = {1'b0, r0} == (rows - SIZE_W'(1));
        f0.row_inner  = r0 >= IDX_W'(2);
        f0.col_inner  = (c0 != '0) && ({1'b0, c0} <= (cols - SIZE_W'(2)));
        f0.hot_first  = r_hot_enable && (r0 != '0) && (tr0 == r_hot_row)
                        && (c0 == r_hot_col);
        f0.hot_last   = r_hot_enable && (r0 == r_hot_row) && (c0 == r_hot_col);
        f0.sweep_last = f0.last_row && col_wrap;
        f0.clr        = (r0 == '0) && (c0 == '0);
        f0.b_zero     = col_wrap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (acc) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // ---------------- line stores ----------------
    // With at least three columns, a line-store entry is read no sooner than two
    // requests after it was written, so the pipeline needs no forwarding.
    logic [DATA_W-1:0] rd_above_a, rd_above_b, rd_two;
    logic [DATA_W-1:0] r_x1;
    logic [IDX_W-1:0]  r_r1, r_c1;
    t_jhs_flags        r_f1;

    jhs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_COLS)) u_row_above (
        .i_clk     (i_clk),
        .i_we      (acc),
        .i_waddr   (c0[COL_AW-1:0]),
        .i_wdata   (s_axis_tdata),
        .i_re      (acc),
        .i_raddr_a (c0[COL_AW-1:0]),
        .i_raddr_b (c0_p1[COL_AW-1:0]),
        .o_rdata_a (rd_above_a),
        .o_rdata_b (rd_above_b)
    );

    jhs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_COLS)) u_row_two_above (
        .i_clk     (i_clk),
        .i_we      (adv1),
        .i_waddr   (r_c1[COL_AW-1:0]),
        .i_wdata   (rd_above_a),
        .i_re      (acc),
        .i_raddr_a (c0[COL_AW-1:0]),
        .i_raddr_b (c0[COL_AW-1:0]),
        .o_rdata_a (rd_two),
        .o_rdata_b ()
    );

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_x1 <= s_axis_tdata;
            r_r1 <= r0;
            r_c1 <= c0;
            r_f1 <= f0;
        end
    end

    // ---------------- stage 1: stencil ----------------
    logic [DATA_W-1:0] r_left;      // value above the previous column
    logic [DATA_W-1:0] nb_right, q1, val1_1, val2_1;
    logic [DATA_W+1:0] sum1;

    always_comb begin
        nb_right = r_f1.b_zero ? '0 : rd_above_b;
        sum1 = {{2{rd_two[DATA_W-1]}}, rd_two} + {{2{r_x1[DATA_W-1]}}, r_x1}
             + {{2{r_left[DATA_W-1]}}, r_left} + {{2{nb_right[DATA_W-1]}}, nb_right};
        // dropping two bits of the two's complement sum rounds towards minus infinity
        q1 = sum1[DATA_W+1:2];
        if (r_f1.hot_first) begin
            val1_1 = r_hot_temp;
        end else if (r_f1.row_inner && r_f1.col_inner) begin
            val1_1 = q1;
        end else begin
            val1_1 = rd_above_a;
        end
        val2_1 = r_f1.hot_last ? r_hot_temp : r_x1;
    end

    logic [DATA_W-1:0] r_val1_2, r_val2_2, r_a2;
    logic [IDX_W-1:0]  r_r2, r_c2;
    t_jhs_flags        r_f2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (adv1) begin
            r_left <= rd_above_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_val1_2 <= val1_1;
            r_val2_2 <= val2_1;
            r_a2     <= rd_above_a;
            r_r2     <= r_r1;
            r_c2     <= r_c1;
            r_f2     <= r_f1;
        end
    end

    // ---------------- stage 2: size of the change ----------------
    logic [DATA_W:0]   diff2, diff2_neg;
    logic [DATA_W-1:0] ad2;

    always_comb begin
        diff2     = {r_a2[DATA_W-1], r_a2} - {r_val1_2[DATA_W-1], r_val1_2};
        diff2_neg = -diff2;
        // |old-new| is below 2^32, so it always fits without saturation
        ad2       = diff2[DATA_W] ? diff2_neg[DATA_W-1:0] : diff2[DATA_W-1:0];
    end

    logic [DATA_W-1:0] r_val1_3, r_val2_3, r_ad3;
    logic [IDX_W-1:0]  r_r3, r_c3;
    t_jhs_flags        r_f3;

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_val1_3 <= r_val1_2;
            r_val2_3 <= r_val2_2;
            r_ad3    <= ad2;
            r_r3     <= r_r2;
            r_c3     <= r_c2;
            r_f3     <= r_f2;
        end
    end

    // ---------------- stage 3: running maximum ----------------
    logic [DATA_W-1:0] r_max, max_base, n_max;

    always_comb begin
        max_base = r_f3.clr ? '0 : r_max;
        n_max    = (r_f3.row_inner && (r_ad3 > max_base)) ? r_ad3 : max_base;
        mask3    = {r_f3.last_row, r_f3.has_first};
    end
    assign load4 = adv3 && (mask3 != 2'b00);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= '0;
        end else if (adv3) begin
            r_max <= n_max;
        end
    end

    // ---------------- stage 4: output register ----------------
    logic [DATA_W-1:0] r_val1_4, r_val2_4, out_val;
    logic [IDX_W-1:0]  r_r4, r_c4, out_row;
    logic              r_sl4;

    always_ff @(posedge i_clk) begin
        if (load4) begin
            r_val1_4 <= r_val1_3;
            r_val2_4 <= r_val2_3;
            r_r4     <= r_r3;
            r_c4     <= r_c3;
            r_sl4    <= r_f3.sweep_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_pend <= 2'b00;
        end else begin
            r_v1 <= acc  || (r_v1 && !adv1);
            r_v2 <= adv1 || (r_v2 && !adv2);
            r_v3 <= adv2 || (r_v3 && !adv3);
            r_v4 <= load4 || (r_v4 && !s4_done);
            if (load4) begin
                r_pend <= mask3;
            end else if (out_fire && (r_pend == 2'b11)) begin
                r_pend <= 2'b10;
            end
        end
    end

    always_comb begin
        out_val      = r_pend[0] ? r_val1_4 : r_val2_4;
        out_row      = r_pend[0] ? (r_r4 - IDX_W'(1)) : r_r4;
        m_axis_tlast = r_pend[0] ? !r_pend[1] : 1'b1;
        m_axis_tuser = r_pend[0] ? 1'b0 : r_sl4;
    end

    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = {(OUT_W - 2*DATA_W - 2*IDX_W)'(0),
                            r_max, r_c4, out_row, out_val};

    // ---------------- assertions ----------------
    property p_pend_nonzero;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> (r_pend != 2'b00);
    endproperty
    a_pend_nonzero: assert property (p_pend_nonzero)
        else $error("output stage holds an item with no result pending");

    property p_pair_second;
        @(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && (r_pend == 2'b11)) |=> (m_axis_tvalid && m_axis_tlast);
    endproperty
    a_pair_second: assert property (p_pair_second)
        else $error("second result of a last-row request was lost");

    property p_max_monotonic;
        @(posedge i_clk) disable iff (!i_rst_n)
        (adv3 && !r_f3.clr) |=> (r_max >= $past(r_max));
    endproperty
    a_max_monotonic: assert property (p_max_monotonic)
        else $error("running maximum decreased within a sweep");

    property p_empty_ready;
        @(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> s_axis_tready;
    endproperty
    a_empty_ready: assert property (p_empty_ready)
        else $error("input stalled while the first stage is empty");

endmodule

/* rtl/core/jhs_ram.sv */
// ----------------------------------------------------------------------------
// jhs_ram
// Generic synchronous RAM: one write port, two read ports, registered reads.
// ----------------------------------------------------------------------------
module jhs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

/* tb/tb_jacobi_heat_stencil_sweep.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_jacobi_heat_stencil_sweep
// Self-checking bench for the Jacobi five-point heat stencil sweep.
// ----------------------------------------------------------------------------
// Grids, some cut short, stream in raster order and every new cell is checked
// against an in-bench prediction of the sweep: stencil value, coordinates,
// running peak change and both end markers. Grid size and hot cell are set
// over the APB port between sweeps and read back. The sender and the
// receiver idle at different rates, and the result side is held off for a
// long stretch once to fill the pipeline.
module tb_jacobi_heat_stencil_sweep;
    import jhs_pkg::*;

    typedef struct {
        logic [DATA_W-1:0] temp;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] peak;
        logic              run_end;
        logic              sweep_end;
    } t_cell_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [APB_W-1:0]    pwdata;
    logic [APB_W-1:0]    prdata;
    logic                pready;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [DATA_W-1:0]   s_axis_tdata;   // [31:0] old_value
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    // [31:0] new_value, [41:32] out_row, [51:42] out_col, [83:52] max_change
    logic [OUT_W-1:0]    m_axis_tdata;
    logic                m_axis_tlast;   // run_last
    logic                m_axis_tuser;   // sweep_last

    jacobi_heat_stencil_sweep i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Predicted sweep state and configuration
    logic [DATA_W-1:0] line_above     [MAX_COLS];
    logic [DATA_W-1:0] line_two_above [MAX_COLS];
    logic [DATA_W-1:0] prev_above;
    int                row_pos;
    int                col_pos;
    logic [DATA_W-1:0] peak_change;
    logic [SIZE_W-1:0] cfg_rows;
    logic [SIZE_W-1:0] cfg_cols;
    logic [IDX_W-1:0]  cfg_hot_row;
    logic [IDX_W-1:0]  cfg_hot_col;
    logic [DATA_W-1:0] cfg_hot_temp;
    logic              cfg_hot_en;

    t_cell_result      expected_cells[$];
    int                fail_count;
    int                cells_sent;
    int                idle_pct;
    int                stall_pct;
    int                hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int grid_extent(input logic [SIZE_W-1:0] v, input int hi);
        if (v < SIZE_W'(MIN_SIZE)) return MIN_SIZE;
        if (v > SIZE_W'(hi)) return hi;
        return int'(v);
    endfunction

    function automatic logic [DATA_W-1:0] random_cell();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            3, 4: return 32'($urandom_range(32'h0020_0000)) - 32'h0010_0000;
            default: return $urandom();
        endcase
    endfunction

    // Works out the results that one accepted request causes.
    task automatic advance_sweep(input logic [DATA_W-1:0] cell_in);
        int                nr;
        int                nc;
        int                r;
        int                c;
        logic [DATA_W-1:0] above;
        logic [DATA_W-1:0] right;
        logic [DATA_W-1:0] two_up;
        logic [DATA_W-1:0] val;
        logic              inner_row;
        longint            acc;
        t_cell_result      res;
        nr = grid_extent(cfg_rows, MAX_ROWS);
        nc = grid_extent(cfg_cols, MAX_COLS);
        r  = row_pos;
        c  = col_pos;
        if (r >= nr || c >= nc) begin
            r = 0;
            c = 0;
        end
        if (r == 0 && c == 0) peak_change = '0;
        above  = line_above[c];
        right  = (c + 1 < nc) ? line_above[c + 1] : '0;
        two_up = line_two_above[c];

        if (r >= 1) begin
            inner_row = (r - 1 >= 1) && (r - 1 <= nr - 2);
            if (cfg_hot_en && (r - 1) == int'(cfg_hot_row) && c == int'(cfg_hot_col)) begin
                val = cfg_hot_temp;
            end else if (inner_row && c >= 1 && c <= nc - 2) begin
                acc = longint'($signed(two_up)) + longint'($signed(cell_in)) +
                      longint'($signed(prev_above)) + longint'($signed(right));
                acc = acc >>> 2;
                val = acc[31:0];
            end else begin
                val = above;
            end
            if (inner_row) begin
                acc = longint'($signed(above)) - longint'($signed(val));
                if (acc < 0) acc = -acc;
                if (acc > longint'(32'hFFFF_FFFF)) acc = longint'(32'hFFFF_FFFF);
                if (acc[31:0] > peak_change) peak_change = acc[31:0];
            end
            res = '{val, IDX_W'(r - 1), IDX_W'(c), peak_change, (r != nr - 1), 1'b0};
            expected_cells.push_back(res);
        end
        // The last row also releases its own cells.
        if (r == nr - 1) begin
            if (cfg_hot_en && r == int'(cfg_hot_row) && c == int'(cfg_hot_col))
                val = cfg_hot_temp;
            else
                val = cell_in;
            res = '{val, IDX_W'(r), IDX_W'(c), peak_change, 1'b1, (c == nc - 1)};
            expected_cells.push_back(res);
        end

        line_two_above[c] = above;
        line_above[c]     = cell_in;
        prev_above        = above;
        c++;
        if (c >= nc) begin
            c = 0;
            r++;
            if (r >= nr) r = 0;
        end
        row_pos = r;
        col_pos = c;
    endtask

    task automatic send_cell(input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do @(posedge i_clk); while (!s_axis_tready);
        advance_sweep(value);
        cells_sent++;
    endtask

    // Writes a register, then reads it back.
    task automatic write_reg(input t_reg_idx idx, input logic [APB_W-1:0] value);
        logic [APB_W-1:0] mask;
        logic [APB_W-1:0] got;
        case (idx)
            REG_ROWS_USED: begin
                mask = 32'h0000_07FF;
                cfg_rows = value[SIZE_W-1:0];
            end
            REG_COLS_USED: begin
                mask = 32'h0000_07FF;
                cfg_cols = value[SIZE_W-1:0];
            end
            REG_HOT_ROW: begin
                mask = 32'h0000_03FF;
                cfg_hot_row = value[IDX_W-1:0];
            end
            REG_HOT_COL: begin
                mask = 32'h0000_03FF;
                cfg_hot_col = value[IDX_W-1:0];
            end
            REG_HOT_TEMP: begin
                mask = 32'hFFFF_FFFF;
                cfg_hot_temp = value;
            end
            default: begin
                mask = 32'h0000_0001;
                cfg_hot_en = value[0];
            end
        endcase
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if ((got & mask) !== (value & mask)) begin
            fail_count++;
            $display("%0t ns: register %s read back expected %h got %h",
                     $time, idx.name(), value & mask, got);
        end
    endtask

    // Waits for every outstanding result, then lets the pipeline settle.
    task automatic wait_drain();
        int guard;
        guard = 0;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_cells.size() != 0 && guard < 50000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (16) @(posedge i_clk);
    endtask

    task automatic set_pacing(input int sender_idle, input int receiver_stall);
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
    endtask

    // Sets the grid size, optionally a fresh hot cell, and streams random cells.
    // A non-zero cut stops the grid early after that many requests.
    task automatic run_grid(input int rows_val, input int cols_val, input int cut,
                            input bit new_hot);
        int nr;
        int nc;
        int cells;
        write_reg(REG_ROWS_USED, 32'(rows_val));
        write_reg(REG_COLS_USED, 32'(cols_val));
        nr = grid_extent(cfg_rows, MAX_ROWS);
        nc = grid_extent(cfg_cols, MAX_COLS);
        if (new_hot) begin
            write_reg(REG_HOT_ROW, ($urandom_range(3) != 0) ? $urandom_range(nr - 1)
                                                            : $urandom_range(1023));
            write_reg(REG_HOT_COL, ($urandom_range(3) != 0) ? $urandom_range(nc - 1)
                                                            : $urandom_range(1023));
            write_reg(REG_HOT_TEMP, random_cell());
            write_reg(REG_HOT_ENABLE, 32'($urandom_range(3) != 0));
        end
        cells = (cut > 0) ? cut : nr * nc;
        repeat (cells) send_cell(random_cell());
        wait_drain();
    endtask

    // Smallest grid with full-scale values; the hot cell sits in the centre
    // but is disabled, so the centre takes the full-range stencil change.
    task automatic test_value_extremes();
        logic [DATA_W-1:0] grid [9] = '{
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF
        };
        set_pacing(0, 0);
        write_reg(REG_ROWS_USED, 32'd2);
        write_reg(REG_COLS_USED, 32'd3);
        write_reg(REG_HOT_ROW, 32'd1);
        write_reg(REG_HOT_COL, 32'd1);
        write_reg(REG_HOT_TEMP, 32'h0000_0000);
        write_reg(REG_HOT_ENABLE, 32'd0);
        foreach (grid[i]) send_cell(grid[i]);
        wait_drain();
    endtask

    // A row cut short by shrinking the width restarts the sweep; the hot cell
    // then sits on the final cell of the last row.
    task automatic test_restart_and_hot_corner();
        set_pacing(0, 0);
        write_reg(REG_HOT_ROW, 32'd2);
        write_reg(REG_HOT_COL, 32'd2);
        write_reg(REG_HOT_TEMP, 32'h8000_0001);
        write_reg(REG_HOT_ENABLE, 32'd1);
        run_grid(0, 5, 4, 1'b0);
        run_grid(0, 3, 0, 1'b0);
    endtask

    task automatic test_backpressure();
        set_pacing(0, 0);
        hold_cycles = 400;
        run_grid(6, 8, 0, 1'b1);
    endtask

    task automatic test_random_sweeps();
        int start;
        int sweep_no;
        int nr;
        int nc;
        start    = cells_sent;
        sweep_no = 0;
        while (cells_sent - start < 650) begin
            case (sweep_no % 4)
                0: set_pacing(0, 0);
                1: set_pacing(61, 0);
                2: set_pacing(0, 61);
                default: set_pacing(27, 27);
            endcase
            if ($urandom_range(7) == 0) begin
                // Abandon a grid part-way through row three or later, then
                // drop to three rows so that the sweep starts over.
                nr = $urandom_range(5, 8);
                nc = $urandom_range(3, 8);
                run_grid(nr, nc, $urandom_range(3, nr - 1) * nc + $urandom_range(nc - 1),
                         1'b1);
                run_grid(3, nc, 0, 1'b0);
            end else begin
                run_grid(($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 10),
                         ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 10),
                         0, 1'b1);
            end
            sweep_no++;
        end
    endtask

    // Oversized row count clamped to the maximum, then the widest grid, each
    // streamed only part of the way: the wide one runs past its first row wrap.
    task automatic test_grid_extremes();
        set_pacing(27, 27);
        run_grid(2047, 1, 30, 1'b1);
        set_pacing(0, 0);
        run_grid(0, 1024, 1024 + 40, 1'b1);
    endtask

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                hold_cycles--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t ns: %s expected %h got %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_cell_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_cells.size() == 0) begin
                fail_count++;
                $display("%0t ns: result expected none got tdata %h", $time, m_axis_tdata);
            end else begin
                want = expected_cells.pop_front();
                compare_field("new_value", want.temp, m_axis_tdata[31:0]);
                compare_field("out_row", 32'(want.row), 32'(m_axis_tdata[41:32]));
                compare_field("out_col", 32'(want.col), 32'(m_axis_tdata[51:42]));
                compare_field("max_change", want.peak, m_axis_tdata[83:52]);
                compare_field("run_last", 32'(want.run_end), 32'(m_axis_tlast));
                compare_field("sweep_last", 32'(want.sweep_end), 32'(m_axis_tuser));
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        fail_count    = 0;
        cells_sent    = 0;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_cycles   = 0;
        foreach (line_above[i]) begin
            line_above[i]     = '0;
            line_two_above[i] = '0;
        end
        prev_above   = '0;
        row_pos      = 0;
        col_pos      = 0;
        peak_change  = '0;
        cfg_rows     = ROWS_RST;
        cfg_cols     = COLS_RST;
        cfg_hot_row  = HOT_ROW_RST;
        cfg_hot_col  = HOT_COL_RST;
        cfg_hot_temp = HOT_TEMP_RST;
        cfg_hot_en   = 1'b1;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_value_extremes();
        test_restart_and_hot_corner();
        test_backpressure();
        test_random_sweeps();
        test_grid_extremes();

        if (expected_cells.size() != 0) begin
            fail_count++;
            $display("%0t ns: %0d results expected but never delivered",
                     $time, expected_cells.size());
        end
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
